### rtl/block_allocator_with_file_table_unit_defines.svh
// Assertion macros used by the checker file of the block allocator.
`ifndef BLOCK_ALLOCATOR_WITH_FILE_TABLE_UNIT_DEFINES_SVH
`define BLOCK_ALLOCATOR_WITH_FILE_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst is high.
`define BAFT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst is high.
`define BAFT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/baft_pkg.sv
// Package with the codes, field widths and sequencer states of the block allocator.
package baft_pkg;

  localparam int NAME_W   = 64;
  localparam int CMD_W    = 2;
  localparam int CNT_W    = 4;
  localparam int IDX_W    = 3;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 4;
  localparam int ADDR_W   = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_CREATE = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_LOOKUP = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NO_SPACE  = 3'd1,
    ST_NO_ENTRY  = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_RANGE     = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_ESCAN,
    S_ALLOC,
    S_FIND,
    S_FREE,
    S_READ,
    S_DONE
  } state_t;

endpackage

### rtl/block_allocator_with_file_table_unit.sv
// Top level of the block allocator with its free-block map and file table.
// Each command transaction produces exactly one result transaction. The block works on one
// command at a time under a small sequencer that walks the file table one entry per cycle
// and the free-block map one block per cycle through a RAM read port. A create scans the
// file table for a free entry and then the free-block map until the last requested block
// is found. A delete scans the file table for the name and then frees the blocks of that
// entry. A lookup scans the file table for the name and, when the index is in range, reads
// one block address. The result waits in an output register, so the next command is taken
// while the previous result is still pending. After reset the block runs a clearing pass
// over the free-block map before it accepts a command.
module block_allocator_with_file_table_unit
  import baft_pkg::*;
#(
  parameter int DISK_BLOCKS     = 128,
  parameter int TABLE_ENTRIES   = 16,
  parameter int MAX_FILE_BLOCKS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  logic [CMD_W-1:0]    command,
  input  logic [NAME_W-1:0]   file_name,
  input  logic [CNT_W-1:0]    block_count,
  input  logic [IDX_W-1:0]    block_index,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output logic [STATUS_W-1:0] status,
  output logic [SLOT_W-1:0]   entry_slot,
  output logic [ADDR_W-1:0]   block_address
);

  localparam int BW        = $clog2(DISK_BLOCKS);
  localparam int EW        = $clog2(TABLE_ENTRIES);
  localparam int KW        = $clog2(MAX_FILE_BLOCKS + 1);
  localparam int FCW       = $clog2(DISK_BLOCKS + 1);
  localparam int BLK_DEPTH = TABLE_ENTRIES * MAX_FILE_BLOCKS;
  localparam int BAW       = $clog2(BLK_DEPTH);
  localparam int NMW       = NAME_W + CNT_W;

  localparam logic [BW-1:0] LAST_BLOCK = BW'(DISK_BLOCKS - 1);
  localparam logic [EW-1:0] LAST_ENTRY = EW'(TABLE_ENTRIES - 1);

  state_t                   state, state_next;
  logic [EW-1:0]            ptr, ptr_next;
  logic [BW-1:0]            blk, blk_next;
  logic [KW-1:0]            k, k_next, k_inc;
  logic [KW-1:0]            target, target_next;
  logic [FCW-1:0]           free_count, free_count_next;
  logic [TABLE_ENTRIES-1:0] used, used_next;

  status_t                  res_status, res_status_next;
  logic [EW-1:0]            res_slot, res_slot_next;
  logic [BW-1:0]            res_addr, res_addr_next;
  logic                     rsp_load;

  cmd_t                     cmd_q;
  logic [NAME_W-1:0]        name_q;
  logic [CNT_W-1:0]         count_q;
  logic [IDX_W-1:0]         idx_q;

  logic                     fm_we, fm_wdata, fm_rdata;
  logic [BW-1:0]            fm_waddr;
  logic                     nm_we;
  logic [NMW-1:0]           nm_rdata;
  logic [NAME_W-1:0]        nm_name;
  logic [CNT_W-1:0]         nm_size;
  logic                     bk_we;
  logic [BAW-1:0]           bk_waddr, bk_raddr, blk_base;
  logic [BW-1:0]            bk_rdata;

  assign cmd_ready = (state == S_IDLE);
  assign k_inc     = k + KW'(1);
  assign blk_base  = BAW'(int'(ptr) * MAX_FILE_BLOCKS);
  assign nm_name   = nm_rdata[NAME_W-1:0];
  assign nm_size   = nm_rdata[NAME_W +: CNT_W];

  baft_ram #(.WIDTH(1), .DEPTH(DISK_BLOCKS)) u_free_map (
    .clk   (clk),
    .we    (fm_we),
    .waddr (fm_waddr),
    .wdata (fm_wdata),
    .raddr (blk_next),
    .rdata (fm_rdata)
  );

  baft_ram #(.WIDTH(NMW), .DEPTH(TABLE_ENTRIES)) u_names (
    .clk   (clk),
    .we    (nm_we),
    .waddr (ptr),
    .wdata ({count_q, name_q}),
    .raddr (ptr_next),
    .rdata (nm_rdata)
  );

  baft_ram #(.WIDTH(BW), .DEPTH(BLK_DEPTH)) u_blocks (
    .clk   (clk),
    .we    (bk_we),
    .waddr (bk_waddr),
    .wdata (blk),
    .raddr (bk_raddr),
    .rdata (bk_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      ptr        <= '0;
      blk        <= '0;
      k          <= '0;
      target     <= '0;
      free_count <= FCW'(DISK_BLOCKS - 1);
      used       <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      ptr        <= ptr_next;
      blk        <= blk_next;
      k          <= k_next;
      target     <= target_next;
      free_count <= free_count_next;
      used       <= used_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_status <= res_status_next;
    res_slot   <= res_slot_next;
    res_addr   <= res_addr_next;
    if (cmd_valid && cmd_ready) begin
      cmd_q   <= cmd_t'(command);
      name_q  <= file_name;
      count_q <= block_count;
      idx_q   <= block_index;
    end
    if (rsp_load) begin
      status        <= res_status;
      entry_slot    <= SLOT_W'(res_slot);
      block_address <= ADDR_W'(res_addr);
    end
  end

  always_comb begin
    state_next      = state;
    ptr_next        = ptr;
    blk_next        = blk;
    k_next          = k;
    target_next     = target;
    free_count_next = free_count;
    used_next       = used;
    res_status_next = res_status;
    res_slot_next   = res_slot;
    res_addr_next   = res_addr;
    rsp_load        = 1'b0;
    fm_we           = 1'b0;
    fm_waddr        = blk;
    fm_wdata        = 1'b0;
    nm_we           = 1'b0;
    bk_we           = 1'b0;
    bk_waddr        = blk_base + BAW'(k);
    bk_raddr        = blk_base;

    case (state)
      S_CLEAR: begin
        fm_we    = 1'b1;
        fm_wdata = (blk == '0);
        if (blk == LAST_BLOCK) begin
          blk_next   = '0;
          state_next = S_IDLE;
        end else begin
          blk_next = blk + BW'(1);
        end
      end

      S_IDLE: begin
        ptr_next = '0;
        if (cmd_valid) begin
          state_next = S_DECODE;
        end
      end

      S_DECODE: begin
        res_status_next = ST_OK;
        res_slot_next   = '0;
        res_addr_next   = '0;
        ptr_next        = '0;
        case (cmd_q)
          CMD_CREATE: begin
            if (int'(count_q) > MAX_FILE_BLOCKS || int'(count_q) > int'(free_count)) begin
              res_status_next = ST_NO_SPACE;
              state_next      = S_DONE;
            end else begin
              target_next = KW'(count_q);
              state_next  = S_ESCAN;
            end
          end
          CMD_DELETE, CMD_LOOKUP: begin
            state_next = S_FIND;
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end

      S_ESCAN: begin
        if (!used[ptr]) begin
          nm_we          = 1'b1;
          used_next[ptr] = 1'b1;
          res_slot_next  = ptr;
          k_next         = '0;
          blk_next       = '0;
          state_next     = (target == '0) ? S_DONE : S_ALLOC;
        end else if (ptr == LAST_ENTRY) begin
          res_status_next = ST_NO_ENTRY;
          state_next      = S_DONE;
        end else begin
          ptr_next = ptr + EW'(1);
        end
      end

      S_ALLOC: begin
        blk_next = (blk == LAST_BLOCK) ? '0 : blk + BW'(1);
        if (!fm_rdata) begin
          fm_we           = 1'b1;
          fm_wdata        = 1'b1;
          bk_we           = 1'b1;
          free_count_next = free_count - FCW'(1);
          k_next          = k_inc;
          if (k_inc == target) begin
            state_next = S_DONE;
          end
        end
      end

      S_FIND: begin
        if (used[ptr] && nm_name == name_q) begin
          res_slot_next = ptr;
          if (cmd_q == CMD_DELETE) begin
            k_next      = '0;
            target_next = (int'(nm_size) > MAX_FILE_BLOCKS) ? KW'(MAX_FILE_BLOCKS)
                                                            : KW'(nm_size);
            if (nm_size == '0) begin
              used_next[ptr] = 1'b0;
              state_next     = S_DONE;
            end else begin
              state_next = S_FREE;
            end
          end else if (int'(idx_q) >= int'(nm_size) || int'(idx_q) >= MAX_FILE_BLOCKS) begin
            res_status_next = ST_RANGE;
            state_next      = S_DONE;
          end else begin
            bk_raddr   = blk_base + BAW'(idx_q);
            state_next = S_READ;
          end
        end else if (ptr == LAST_ENTRY) begin
          res_status_next = ST_NOT_FOUND;
          state_next      = S_DONE;
        end else begin
          ptr_next = ptr + EW'(1);
        end
      end

      S_FREE: begin
        fm_waddr = bk_rdata;
        if (int'(bk_rdata) < DISK_BLOCKS) begin
          fm_we           = 1'b1;
          free_count_next = free_count + FCW'(1);
        end
        k_next = k_inc;
        if (k_inc == target) begin
          used_next[ptr] = 1'b0;
          state_next     = S_DONE;
        end else begin
          bk_raddr = blk_base + BAW'(k_inc);
        end
      end

      S_READ: begin
        res_addr_next = bk_rdata;
        state_next    = S_DONE;
      end

      S_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          rsp_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/baft_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module baft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/baft_checker.sv
// Port-level checker for the block allocator and its bind to the top level.
`include "block_allocator_with_file_table_unit_defines.svh"

module baft_checker
  import baft_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                cmd_valid,
  input logic                cmd_ready,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input logic [STATUS_W-1:0] status,
  input logic [SLOT_W-1:0]   entry_slot,
  input logic [ADDR_W-1:0]   block_address
);

  `BAFT_ASSERT_NXT(a_busy_after_cmd, cmd_valid && cmd_ready, !cmd_ready, "ready after accept")
  `BAFT_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(status) && $stable(entry_slot) && $stable(block_address), "stalled result changed")
  `BAFT_ASSERT_IMP(a_fail_addr, rsp_valid && status != ST_OK, block_address == '0, "address on failure")
  `BAFT_ASSERT_IMP(a_fail_slot, rsp_valid && (status == ST_NO_SPACE || status == ST_NO_ENTRY || status == ST_NOT_FOUND), entry_slot == '0, "slot on failure")
  `BAFT_ASSERT_IMP(a_rsp_idle, $rose(rsp_valid), cmd_ready, "result while busy")

endmodule

bind block_allocator_with_file_table_unit baft_checker u_baft_checker (.*);
